// ----- sv/rbst_pkg.sv -----
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared widths, reset values and inter-stage types for the ray/box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int COORD_W  = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int EPS_W    = 16;
  localparam int NUM_AXES = 3;
  localparam int S_DATA_W = 4 * NUM_AXES * COORD_W;
  localparam int M_DATA_W = 8;

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

  // Per-axis side information that travels alongside the dividers.
  typedef struct packed {
    logic parallel;
    logic in_slab;
    logic neg_min;
    logic neg_max;
  } axis_flags_t;

  // Magnitudes handed from the set-up stages to an axis divider.
  typedef struct packed {
    axis_flags_t        flags;
    logic [COORD_W-1:0] dir_mag;
    logic [COORD_W-1:0] min_mag;
    logic [COORD_W-1:0] max_mag;
  } axis_prep_t;

endpackage

// ----- sv/rbst_prep.sv -----
// ----------------------------------------------------------------------------
// rbst_prep
// Two set-up stages: slab distances, then magnitudes, signs and slab flags.
// ----------------------------------------------------------------------------
module rbst_prep (
  input  logic                                           clk,
  input  logic [1:0]                                     en,
  input  logic [rbst_pkg::S_DATA_W-1:0]                  item,
  input  logic [rbst_pkg::EPS_W-1:0]                     dir_epsilon,
  output rbst_pkg::axis_prep_t [rbst_pkg::NUM_AXES-1:0]  prep
);
  import rbst_pkg::*;

  localparam int FIELD_ORIGIN = 0;
  localparam int FIELD_DIR    = NUM_AXES;
  localparam int FIELD_MIN    = 2 * NUM_AXES;
  localparam int FIELD_MAX    = 3 * NUM_AXES;

  logic [COORD_W-1:0] org_f [NUM_AXES];
  logic [COORD_W-1:0] dir_f [NUM_AXES];
  logic [COORD_W-1:0] min_f [NUM_AXES];
  logic [COORD_W-1:0] max_f [NUM_AXES];

  logic signed [DIFF_W-1:0]  dmin [NUM_AXES];
  logic signed [DIFF_W-1:0]  dmax [NUM_AXES];
  logic signed [COORD_W-1:0] dir  [NUM_AXES];

  logic [DIFF_W-1:0]  dir_neg [NUM_AXES];
  logic [DIFF_W-1:0]  min_neg [NUM_AXES];
  logic [DIFF_W-1:0]  max_neg [NUM_AXES];
  axis_prep_t         prep_next [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      org_f[a] = item[(FIELD_ORIGIN + a) * COORD_W +: COORD_W];
      dir_f[a] = item[(FIELD_DIR + a) * COORD_W +: COORD_W];
      min_f[a] = item[(FIELD_MIN + a) * COORD_W +: COORD_W];
      max_f[a] = item[(FIELD_MAX + a) * COORD_W +: COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        dmin[a] <= $signed({min_f[a][COORD_W-1], min_f[a]}) -
                   $signed({org_f[a][COORD_W-1], org_f[a]});
        dmax[a] <= $signed({max_f[a][COORD_W-1], max_f[a]}) -
                   $signed({org_f[a][COORD_W-1], org_f[a]});
        dir[a]  <= $signed(dir_f[a]);
      end
    end
  end

  // A slab distance never exceeds 2^32 - 1 in magnitude, so 32 bits hold it.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      dir_neg[a] = -{dir[a][COORD_W-1], dir[a]};
      min_neg[a] = -dmin[a];
      max_neg[a] = -dmax[a];
      prep_next[a].dir_mag = dir[a][COORD_W-1] ? dir_neg[a][COORD_W-1:0] : dir[a];
      prep_next[a].min_mag = dmin[a][DIFF_W-1] ? min_neg[a][COORD_W-1:0]
                                               : dmin[a][COORD_W-1:0];
      prep_next[a].max_mag = dmax[a][DIFF_W-1] ? max_neg[a][COORD_W-1:0]
                                               : dmax[a][COORD_W-1:0];
      prep_next[a].flags.parallel =
        prep_next[a].dir_mag <= {{(COORD_W-EPS_W){1'b0}}, dir_epsilon};
      prep_next[a].flags.in_slab = (dmin[a][DIFF_W-1] || (dmin[a] == '0)) &&
                                   !dmax[a][DIFF_W-1];
      prep_next[a].flags.neg_min = dmin[a][DIFF_W-1] ^ dir[a][COORD_W-1];
      prep_next[a].flags.neg_max = dmax[a][DIFF_W-1] ^ dir[a][COORD_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prep[a] <= prep_next[a];
      end
    end
  end

endmodule

// ----- sv/rbst_axis_div.sv -----
// ----------------------------------------------------------------------------
// rbst_axis_div
// Pipelined restoring divider for one axis: both slab parameters, one
// quotient bit per stage, unsigned magnitudes.
// ----------------------------------------------------------------------------
module rbst_axis_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic [rbst_pkg::COORD_W+FRAC_BITS-1:0]     en,
  input  rbst_pkg::axis_prep_t                       prep_in,
  output logic [rbst_pkg::COORD_W+FRAC_BITS-1:0]     q_min,
  output logic [rbst_pkg::COORD_W+FRAC_BITS-1:0]     q_max,
  output rbst_pkg::axis_flags_t                      flags_out
);
  import rbst_pkg::*;

  localparam int NW = COORD_W + FRAC_BITS;

  // Returns the quotient bit above the new partial remainder.
  function automatic logic [COORD_W:0] div_step(input logic [COORD_W-1:0] rem,
                                                input logic                bit_in,
                                                input logic [COORD_W-1:0] divisor);
    logic [COORD_W:0] trial;
    logic [COORD_W:0] diff;
    trial = {rem, bit_in};
    diff  = trial - {1'b0, divisor};
    if (diff[COORD_W]) begin
      div_step = {1'b0, trial[COORD_W-1:0]};
    end else begin
      div_step = {1'b1, diff[COORD_W-1:0]};
    end
  endfunction

  // Each stage holds the divisor, both remainders and a combined
  // numerator/quotient word: numerator bits leave at the top while quotient
  // bits enter at the bottom.
  logic [COORD_W-1:0] divisor [NW];
  logic [COORD_W-1:0] rem_min [NW];
  logic [COORD_W-1:0] rem_max [NW];
  logic [NW-1:0]      nq_min  [NW];
  logic [NW-1:0]      nq_max  [NW];
  axis_flags_t        flg     [NW];

  logic [COORD_W-1:0] src_div  [NW];
  logic [COORD_W-1:0] src_rmin [NW];
  logic [COORD_W-1:0] src_rmax [NW];
  logic [NW-1:0]      src_nmin [NW];
  logic [NW-1:0]      src_nmax [NW];
  axis_flags_t        src_flg  [NW];
  logic [COORD_W:0]   st_min   [NW];
  logic [COORD_W:0]   st_max   [NW];

  always_comb begin
    for (int j = 0; j < NW; j++) begin
      if (j == 0) begin
        src_div[j]  = prep_in.dir_mag;
        src_rmin[j] = '0;
        src_rmax[j] = '0;
        src_nmin[j] = {prep_in.min_mag, {FRAC_BITS{1'b0}}};
        src_nmax[j] = {prep_in.max_mag, {FRAC_BITS{1'b0}}};
        src_flg[j]  = prep_in.flags;
      end else begin
        src_div[j]  = divisor[j-1];
        src_rmin[j] = rem_min[j-1];
        src_rmax[j] = rem_max[j-1];
        src_nmin[j] = nq_min[j-1];
        src_nmax[j] = nq_max[j-1];
        src_flg[j]  = flg[j-1];
      end
      st_min[j] = div_step(src_rmin[j], src_nmin[j][NW-1], src_div[j]);
      st_max[j] = div_step(src_rmax[j], src_nmax[j][NW-1], src_div[j]);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NW; j++) begin
      if (en[j]) begin
        divisor[j] <= src_div[j];
        rem_min[j] <= st_min[j][COORD_W-1:0];
        rem_max[j] <= st_max[j][COORD_W-1:0];
        nq_min[j]  <= {src_nmin[j][NW-2:0], st_min[j][COORD_W]};
        nq_max[j]  <= {src_nmax[j][NW-2:0], st_max[j][COORD_W]};
        flg[j]     <= src_flg[j];
      end
    end
  end

  assign q_min     = nq_min[NW-1];
  assign q_max     = nq_max[NW-1];
  assign flags_out = flg[NW-1];

endmodule

// ----- sv/rbst_merge.sv -----
// ----------------------------------------------------------------------------
// rbst_merge
// Applies signs, orders each axis's parameters, narrows the interval over
// the three axes and forms the hit flag, in five register stages.
// ----------------------------------------------------------------------------
module rbst_merge #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                                            clk,
  input  logic [4:0]                                                      en,
  input  logic [rbst_pkg::NUM_AXES-1:0][rbst_pkg::COORD_W+FRAC_BITS-1:0] q_min,
  input  logic [rbst_pkg::NUM_AXES-1:0][rbst_pkg::COORD_W+FRAC_BITS-1:0] q_max,
  input  rbst_pkg::axis_flags_t [rbst_pkg::NUM_AXES-1:0]                  flags,
  output logic                                                            hit
);
  import rbst_pkg::*;

  localparam int NW = COORD_W + FRAC_BITS;
  localparam int TW = NW + 1;

  // Stage 0: signed parameters.
  logic signed [TW-1:0] ta [NUM_AXES];
  logic signed [TW-1:0] tb [NUM_AXES];
  axis_flags_t          f0 [NUM_AXES];

  // Stage 1: ordered pair per axis.
  logic signed [TW-1:0] lo1 [NUM_AXES];
  logic signed [TW-1:0] hi1 [NUM_AXES];
  logic [NUM_AXES-1:0]  use1;
  logic                 pmiss1;

  // Stage 2: x and y merged, z carried.
  logic signed [TW-1:0] lo2, hi2, lo2z, hi2z;
  logic                 use2, use2z, pmiss2;

  // Stage 3: all axes merged.
  logic signed [TW-1:0] lo3, hi3;
  logic                 use3, pmiss3;

  logic [NUM_AXES-1:0]  pmiss_axis;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        ta[a] <= flags[a].neg_min ? -$signed({1'b0, q_min[a]}) : $signed({1'b0, q_min[a]});
        tb[a] <= flags[a].neg_max ? -$signed({1'b0, q_max[a]}) : $signed({1'b0, q_max[a]});
        f0[a] <= flags[a];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      pmiss_axis[a] = f0[a].parallel && !f0[a].in_slab;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        lo1[a]  <= (ta[a] <= tb[a]) ? ta[a] : tb[a];
        hi1[a]  <= (ta[a] <= tb[a]) ? tb[a] : ta[a];
        use1[a] <= !f0[a].parallel;
      end
      pmiss1 <= |pmiss_axis;
    end
  end

  // A parallel axis leaves the interval as it is; when neither side bounds
  // it, the interval stays unbounded and the use flag stays low.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (use1[0] && use1[1]) begin
        lo2 <= (lo1[0] > lo1[1]) ? lo1[0] : lo1[1];
        hi2 <= (hi1[0] < hi1[1]) ? hi1[0] : hi1[1];
      end else if (use1[0]) begin
        lo2 <= lo1[0];
        hi2 <= hi1[0];
      end else begin
        lo2 <= lo1[1];
        hi2 <= hi1[1];
      end
      use2   <= use1[0] || use1[1];
      lo2z   <= lo1[2];
      hi2z   <= hi1[2];
      use2z  <= use1[2];
      pmiss2 <= pmiss1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (use2 && use2z) begin
        lo3 <= (lo2 > lo2z) ? lo2 : lo2z;
        hi3 <= (hi2 < hi2z) ? hi2 : hi2z;
      end else if (use2) begin
        lo3 <= lo2;
        hi3 <= hi2;
      end else begin
        lo3 <= lo2z;
        hi3 <= hi2z;
      end
      use3   <= use2 || use2z;
      pmiss3 <= pmiss2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hit <= !pmiss3 && (!use3 || ((lo3 <= hi3) && !hi3[TW-1]));
    end
  end

endmodule

// ----- sv/ray_box_slab_test_core.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_test_core
// Ray versus axis-aligned box slab test in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one word per ray/box pair: twelve signed 32-bit
//   coordinates with FRAC_BITS fraction bits. The master stream returns one
//   word per pair whose bit 0 is the hit flag. cfg_we writes the parallel
//   threshold dir_epsilon from cfg_wdata; change it only while idle.
//   Throughput is one word per cycle while the output is not stalled. From
//   acceptance to m_tvalid a word passes two set-up stages, one stage per
//   quotient bit of the 32 + FRAC_BITS bit slab divisions, and five
//   stages of sign, ordering, interval merging and the final compare.
//   Reset empties the pipeline and sets dir_epsilon to 1. When the receiver
//   stalls, words close up behind the waiting result, so s_tready stays high
//   while any stage is empty; it drops only when every stage is full and
//   m_tready is low. No word is lost or repeated.
// ----------------------------------------------------------------------------
module ray_box_slab_test_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata, lowest bit up: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rbst_pkg::S_DATA_W-1:0] s_tdata,
  // m_tdata, lowest bit up: hit, then seven zero bits.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rbst_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                          cfg_we,
  input  logic [rbst_pkg::EPS_W-1:0]    cfg_wdata
);
  import rbst_pkg::*;

  localparam int NW       = COORD_W + FRAC_BITS;
  localparam int PREP_ST  = 2;
  localparam int MERGE_ST = 5;
  localparam int DEPTH    = PREP_ST + NW + MERGE_ST;

  logic [EPS_W-1:0] dir_epsilon;
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] valid_next;
  logic [DEPTH-1:0] rdy;

  axis_prep_t [NUM_AXES-1:0]          prep;
  logic [NUM_AXES-1:0][NW-1:0]        q_min;
  logic [NUM_AXES-1:0][NW-1:0]        q_max;
  axis_flags_t [NUM_AXES-1:0]         div_flags;
  logic                               hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_epsilon <= EPS_RESET;
    end else if (cfg_we) begin
      dir_epsilon <= cfg_wdata;
    end
  end

  // A stage may load when it, or any stage after it, is empty, or when the
  // output word is being taken.
  for (genvar k = 0; k < DEPTH; k++) begin : g_rdy
    assign rdy[k] = m_tready || !(&valid[DEPTH-1:k]);
  end

  assign valid_next = ({valid[DEPTH-2:0], s_tvalid} & rdy) | (valid & ~rdy);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  rbst_prep u_prep (
    .clk         (clk),
    .en          (rdy[PREP_ST-1:0]),
    .item        (s_tdata),
    .dir_epsilon (dir_epsilon),
    .prep        (prep)
  );

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbst_axis_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk       (clk),
      .en        (rdy[PREP_ST +: NW]),
      .prep_in   (prep[a]),
      .q_min     (q_min[a]),
      .q_max     (q_max[a]),
      .flags_out (div_flags[a])
    );
  end

  rbst_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk   (clk),
    .en    (rdy[PREP_ST+NW +: MERGE_ST]),
    .q_min (q_min),
    .q_max (q_max),
    .flags (div_flags),
    .hit   (hit)
  );

  assign s_tready = rdy[0];
  assign m_tvalid = valid[DEPTH-1];
  assign m_tdata  = {{(M_DATA_W-1){1'b0}}, hit};

endmodule

// ----- sv/rbst_checker.sv -----
// ----------------------------------------------------------------------------
// rbst_checker
// Port-level checks on the slab test core, bound to every instance.
// ----------------------------------------------------------------------------
module rbst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rbst_pkg::M_DATA_W-1:0] m_tdata
);
  import rbst_pkg::*;

  // Reset empties the whole pipeline, so m_tvalid is low after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // A word that is not taken stays as it is.
  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // Input is refused only when the pipeline is full and the output stalls.
  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
      !s_tready |-> m_tvalid && !m_tready)
    else $error("s_tready low with room in the pipeline");

  // Only the hit flag may be set in a result word.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> m_tdata[M_DATA_W-1:1] == '0)
    else $error("padding bits of m_tdata set");

endmodule

bind ray_box_slab_test_core rbst_checker u_rbst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
